>>> rtl/cde_pkg.sv
// cde_pkg: types, constants and helpers for the clock digit editor
// no dependencies; imported by the top level and the testbench

package cde_pkg;

    localparam int unsigned NUM_DIGITS = 4;
    localparam int unsigned MAX_WRITES = 5;
    localparam int unsigned CNT_W      = 3;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 8;

    typedef enum logic [3:0] {
        REQ_SET_TIME    = 4'd0,
        REQ_CURSOR_ON   = 4'd1,
        REQ_CURSOR_OFF  = 4'd2,
        REQ_MOVE_LEFT   = 4'd3,
        REQ_MOVE_RIGHT  = 4'd4,
        REQ_INCREMENT   = 4'd5,
        REQ_BLINK_TICK  = 4'd6,
        REQ_DISPLAY_OFF = 4'd7,
        REQ_DISPLAY_ON  = 4'd8
    } req_code_t;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURSOR_ALLOWED = 1'd1;

    localparam logic [2:0] CURSOR_OFF = 3'd4;
    localparam logic [7:0] SEG_BLANK  = 8'h00;

    localparam logic [7:0] SEG_CODES [10] = '{
        8'h3f, 8'h06, 8'h5b, 8'h4f, 8'h66, 8'h6d, 8'h7d, 8'h07, 8'h7f, 8'h6f
    };

    typedef struct packed {
        logic       is_brightness;
        logic [1:0] digit_index;
        logic [7:0] segments;
        logic       last;
    } write_t;

    function automatic logic [7:0] seg_of(input logic [3:0] v);
        logic [7:0] s;
        s = SEG_BLANK;
        if (v <= 4'd9)
        begin
            s = SEG_CODES[v];
        end
        return s;
    endfunction

    function automatic write_t mk_write(input logic b, input logic [1:0] idx,
                                        input logic [7:0] seg);
        write_t w;
        w.is_brightness = b;
        w.digit_index   = idx;
        w.segments      = seg;
        w.last          = 1'b0;
        return w;
    endfunction

endpackage

>>> rtl/cde_if.sv
// cde_if: valid/ready channels for editor requests and display writes
// no dependencies; used by the top level and the testbench

interface cde_req_if;
    logic       valid;
    logic       ready;
    logic [3:0] req_type;
    logic [6:0] hours;
    logic [6:0] minutes;

    modport source (output valid, output req_type, output hours, output minutes,
                    input ready);
    modport sink   (input valid, input req_type, input hours, input minutes,
                    output ready);
endinterface

interface cde_wr_if;
    logic       valid;
    logic       ready;
    logic       is_brightness;
    logic [1:0] digit_index;
    logic [7:0] segments;
    logic       last;

    modport source (output valid, output is_brightness, output digit_index,
                    output segments, output last, input ready);
    modport sink   (input valid, input is_brightness, input digit_index,
                    input segments, input last, output ready);
endinterface

>>> rtl/clock_digit_editor_display.sv
// clock_digit_editor_display: four-digit HH:MM editor that turns set time, cursor,
// increment, blink and display on/off requests into seven-segment display writes;
// depends on cde_pkg and cde_if. Each request is decoded in the cycle of its
// transfer: the digit, cursor and blink state update at once and the writes it
// causes (zero to five) are captured as a batch, which drains one write per cycle
// through a registered output stage while the display is ready. A request with
// writes holds off the next one until its final write enters the output register,
// and the next request can transfer in that same cycle. Configuration writes
// (brightness byte, cursor enable) take effect on the next request.

module clock_digit_editor_display
    import cde_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    cde_req_if.sink               req,
    cde_wr_if.source              disp
);

    logic [3:0]        digit_reg [NUM_DIGITS];
    logic [3:0]        digit_next [NUM_DIGITS];
    logic [2:0]        cursor_reg, cursor_next;
    logic              blink_reg, blink_next;
    logic [7:0]        brightness_reg;
    logic              cursor_allowed_reg;

    write_t            batch_reg [MAX_WRITES];
    write_t            batch_next [MAX_WRITES];
    logic [CNT_W-1:0]  pend_cnt_reg, pend_cnt_next;
    write_t            out_reg, out_next;
    logic              out_valid_reg, out_valid_next;

    write_t            items [MAX_WRITES];
    logic [CNT_W-1:0]  n_items;
    logic [3:0]        new_digits [NUM_DIGITS];

    logic              load;
    logic              accept;
    logic              cursor_on;
    logic [1:0]        cur_idx;
    logic [3:0]        cur_val;
    logic [3:0]        limit;
    logic [14:0]       prod_h, prod_m;
    logic [3:0]        q_h, q_m;
    logic [6:0]        rem_h, rem_m;

    assign load      = (pend_cnt_reg != '0) && (!out_valid_reg || disp.ready);
    assign req.ready = (pend_cnt_reg == '0) || ((pend_cnt_reg == CNT_W'(1)) && load);
    assign accept    = req.valid && req.ready;

    assign cursor_on = !cursor_reg[2];
    assign cur_idx   = cursor_reg[1:0];
    assign cur_val   = digit_reg[cur_idx];

    // divide by ten through a reciprocal, exact for seven-bit values
    assign prod_h = 15'(req.hours) * 15'd205;
    assign prod_m = 15'(req.minutes) * 15'd205;
    assign q_h    = prod_h[14:11];
    assign q_m    = prod_m[14:11];
    assign rem_h  = req.hours - 7'(q_h * 7'd10);
    assign rem_m  = req.minutes - 7'(q_m * 7'd10);

    always_comb
    begin
        new_digits[0] = q_h;
        new_digits[1] = rem_h[3:0];
        new_digits[2] = q_m;
        new_digits[3] = rem_m[3:0];

        if (cur_idx == 2'd0)
        begin
            limit = 4'd2;
        end
        else if (cur_idx == 2'd1)
        begin
            limit = (digit_reg[0] == 4'd2) ? 4'd3 : 4'd9;
        end
        else if (cur_idx == 2'd2)
        begin
            limit = 4'd5;
        end
        else
        begin
            limit = 4'd9;
        end
    end

    // request decode: next state and the batch of writes
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            digit_next[i] = digit_reg[i];
        end
        cursor_next = cursor_reg;
        blink_next  = blink_reg;
        n_items     = '0;
        for (int i = 0; i < MAX_WRITES; i++)
        begin
            items[i] = mk_write(1'b0, 2'd0, SEG_BLANK);
        end

        unique case (req.req_type) inside
            REQ_SET_TIME:
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    digit_next[i] = new_digits[i];
                    if (new_digits[i] <= 4'd9)
                    begin
                        items[n_items] = mk_write(1'b0, 2'(i), seg_of(new_digits[i]));
                        n_items        = n_items + CNT_W'(1);
                    end
                end
            end
            REQ_CURSOR_ON, REQ_CURSOR_OFF:
            begin
                if (req.req_type == REQ_CURSOR_ON && cursor_allowed_reg)
                begin
                    cursor_next = 3'd0;
                end
                else
                begin
                    if (cursor_on)
                    begin
                        items[0] = mk_write(1'b0, cur_idx, seg_of(cur_val));
                        n_items  = CNT_W'(1);
                    end
                    cursor_next = CURSOR_OFF;
                end
            end
            REQ_MOVE_LEFT, REQ_MOVE_RIGHT:
            begin
                if (cursor_allowed_reg && cursor_on)
                begin
                    items[0] = mk_write(1'b0, cur_idx, seg_of(cur_val));
                    n_items  = CNT_W'(1);
                    if (req.req_type == REQ_MOVE_LEFT)
                    begin
                        cursor_next = {1'b0, cur_idx - 2'd1};
                    end
                    else
                    begin
                        cursor_next = {1'b0, cur_idx + 2'd1};
                    end
                end
            end
            REQ_INCREMENT:
            begin
                if (cursor_on)
                begin
                    digit_next[cur_idx] = (cur_val >= limit) ? 4'd0 : cur_val + 4'd1;
                end
            end
            REQ_BLINK_TICK:
            begin
                if (cursor_on)
                begin
                    blink_next = !blink_reg;
                    items[0]   = mk_write(1'b0, cur_idx,
                                          blink_reg ? SEG_BLANK : seg_of(cur_val));
                    n_items    = CNT_W'(1);
                end
            end
            REQ_DISPLAY_OFF:
            begin
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    items[i] = mk_write(1'b0, 2'(i), SEG_BLANK);
                end
                n_items = CNT_W'(NUM_DIGITS);
            end
            REQ_DISPLAY_ON:
            begin
                items[0] = mk_write(1'b1, 2'd0, brightness_reg);
                for (int i = 0; i < NUM_DIGITS; i++)
                begin
                    items[i+1] = mk_write(1'b0, 2'(i), SEG_CODES[0]);
                end
                n_items = CNT_W'(MAX_WRITES);
            end
            default:
            begin
                n_items = '0;
            end
        endcase

        for (int i = 0; i < MAX_WRITES; i++)
        begin
            if (CNT_W'(i) + CNT_W'(1) == n_items)
            begin
                items[i].last = 1'b1;
            end
        end
    end

    // batch buffer and output stage
    always_comb
    begin
        batch_next     = batch_reg;
        pend_cnt_next  = pend_cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (load)
        begin
            out_next       = batch_reg[0];
            out_valid_next = 1'b1;
            for (int i = 0; i < MAX_WRITES - 1; i++)
            begin
                batch_next[i] = batch_reg[i+1];
            end
            pend_cnt_next = pend_cnt_reg - CNT_W'(1);
        end
        else if (disp.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept)
        begin
            batch_next    = items;
            pend_cnt_next = n_items;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg[0]       <= 4'd1;
            digit_reg[1]       <= 4'd2;
            digit_reg[2]       <= 4'd0;
            digit_reg[3]       <= 4'd0;
            cursor_reg         <= CURSOR_OFF;
            blink_reg          <= 1'b0;
            brightness_reg     <= '0;
            cursor_allowed_reg <= 1'b1;
            pend_cnt_reg       <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                digit_reg  <= digit_next;
                cursor_reg <= cursor_next;
                blink_reg  <= blink_next;
            end
            if (wr_en)
            begin
                if (wr_index == REG_BRIGHTNESS)
                begin
                    brightness_reg <= wr_data;
                end
                if (wr_index == REG_CURSOR_ALLOWED)
                begin
                    cursor_allowed_reg <= wr_data[0];
                end
            end
            pend_cnt_reg  <= pend_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        batch_reg <= batch_next;
        out_reg   <= out_next;
    end

    assign disp.valid         = out_valid_reg;
    assign disp.is_brightness = out_reg.is_brightness;
    assign disp.digit_index   = out_reg.digit_index;
    assign disp.segments      = out_reg.segments;
    assign disp.last          = out_reg.last;

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg <= CNT_W'(MAX_WRITES))
        else $error("pending write count out of range");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        pend_cnt_reg > CNT_W'(1) |-> !req.ready)
        else $error("request taken while a batch is still draining");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= CURSOR_OFF)
        else $error("cursor position out of range");

    a_drain_gap: assert property (@(posedge clk) disable iff (!rst_n)
        disp.valid && disp.ready && disp.last && pend_cnt_reg == '0 |=> !disp.valid)
        else $error("write shown after the final transfer with nothing pending");

    a_blink_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(blink_reg) |-> $past(req.valid && req.ready))
        else $error("blink phase changed without a request transfer");

endmodule

>>> dv/testbench.sv
// testbench: self-checking bench for clock_digit_editor_display
// drives editor requests and checks each display write against an in-bench
// predictor or a typed table; depends on cde_pkg, cde_if and the rtl top level

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cde_pkg::*;

    localparam logic [3:0] REQ_UNKNOWN_LO = 4'd9;
    localparam logic [3:0] REQ_UNKNOWN_HI = 4'd15;
    localparam int PREDICTED        = -1;
    localparam int NUM_DIRECTED     = 24;
    localparam int NUM_TYPED        = 19;
    localparam int NUM_PHASES       = 6;
    localparam int ITEMS_PER_PHASE  = 35;
    localparam int DRAIN_CYCLES     = 8;
    localparam int TAIL_CYCLES      = 20;
    localparam int WATCHDOG_LIMIT   = 1000;

    typedef struct packed {
        logic [3:0] code;
        logic [6:0] hrs;
        logic [6:0] mins;
        int         n_typed;
    } stim_row_t;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{REQ_CURSOR_OFF,  7'd0,   7'd0,   0},
        '{REQ_BLINK_TICK,  7'd0,   7'd0,   0},
        '{REQ_INCREMENT,   7'd0,   7'd0,   0},
        '{REQ_MOVE_RIGHT,  7'd0,   7'd0,   0},
        '{REQ_DISPLAY_ON,  7'd0,   7'd0,   5},
        '{REQ_DISPLAY_OFF, 7'd0,   7'd0,   4},
        '{REQ_SET_TIME,    7'd0,   7'd0,   4},
        '{REQ_SET_TIME,    7'd99,  7'd99,  4},
        '{REQ_SET_TIME,    7'd127, 7'd127, 2},
        '{REQ_UNKNOWN_LO,  7'd127, 7'd127, 0},
        '{REQ_UNKNOWN_HI,  7'd0,   7'd0,   0},
        '{REQ_CURSOR_ON,   7'd0,   7'd0,   PREDICTED},
        '{REQ_BLINK_TICK,  7'd0,   7'd0,   PREDICTED},
        '{REQ_INCREMENT,   7'd0,   7'd0,   PREDICTED},
        '{REQ_BLINK_TICK,  7'd0,   7'd0,   PREDICTED},
        '{REQ_BLINK_TICK,  7'd0,   7'd0,   PREDICTED},
        '{REQ_MOVE_LEFT,   7'd0,   7'd0,   PREDICTED},
        '{REQ_MOVE_RIGHT,  7'd0,   7'd0,   PREDICTED},
        '{REQ_SET_TIME,    7'd23,  7'd59,  PREDICTED},
        '{REQ_MOVE_RIGHT,  7'd0,   7'd0,   PREDICTED},
        '{REQ_INCREMENT,   7'd0,   7'd0,   PREDICTED},
        '{REQ_MOVE_RIGHT,  7'd0,   7'd0,   PREDICTED},
        '{REQ_INCREMENT,   7'd0,   7'd0,   PREDICTED},
        '{REQ_CURSOR_OFF,  7'd0,   7'd0,   PREDICTED}
    };

    write_t typed_writes [NUM_TYPED] = '{
        '{1'b1, 2'd0, 8'h00, 1'b0},
        '{1'b0, 2'd0, 8'h3f, 1'b0},
        '{1'b0, 2'd1, 8'h3f, 1'b0},
        '{1'b0, 2'd2, 8'h3f, 1'b0},
        '{1'b0, 2'd3, 8'h3f, 1'b1},
        '{1'b0, 2'd0, 8'h00, 1'b0},
        '{1'b0, 2'd1, 8'h00, 1'b0},
        '{1'b0, 2'd2, 8'h00, 1'b0},
        '{1'b0, 2'd3, 8'h00, 1'b1},
        '{1'b0, 2'd0, 8'h3f, 1'b0},
        '{1'b0, 2'd1, 8'h3f, 1'b0},
        '{1'b0, 2'd2, 8'h3f, 1'b0},
        '{1'b0, 2'd3, 8'h3f, 1'b1},
        '{1'b0, 2'd0, 8'h6f, 1'b0},
        '{1'b0, 2'd1, 8'h6f, 1'b0},
        '{1'b0, 2'd2, 8'h6f, 1'b0},
        '{1'b0, 2'd3, 8'h6f, 1'b1},
        '{1'b0, 2'd1, 8'h07, 1'b0},
        '{1'b0, 2'd3, 8'h07, 1'b1}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    cde_req_if req_ch ();
    cde_wr_if  disp_ch ();

    logic [3:0] model_digits [NUM_DIGITS];
    logic [2:0] model_cursor;
    logic       model_blink;
    logic [7:0] shadow_brightness;
    logic       shadow_cursor_allowed;

    write_t event_writes [$];
    write_t pending_writes [$];
    int     row_typed;
    int     typed_ptr;
    int     mismatch_count;
    int     stall_cycles;
    int     sender_idle_pct;
    int     receiver_idle_pct;

    clock_digit_editor_display i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .req      (req_ch),
        .disp     (disp_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [7:0] segment_pattern(input logic [3:0] v);
        return (v <= 4'd9) ? SEG_CODES[v] : SEG_BLANK;
    endfunction

    function automatic void add_write(input logic b, input logic [1:0] idx,
                                      input logic [7:0] seg);
        event_writes.push_back('{b, idx, seg, 1'b0});
    endfunction

    function automatic void restore_digit();
        if (model_cursor < CURSOR_OFF)
        begin
            add_write(1'b0, model_cursor[1:0], segment_pattern(model_digits[model_cursor[1:0]]));
        end
    endfunction

    function automatic void reset_model();
        model_digits[0]       = 4'd1;
        model_digits[1]       = 4'd2;
        model_digits[2]       = 4'd0;
        model_digits[3]       = 4'd0;
        model_cursor          = CURSOR_OFF;
        model_blink           = 1'b0;
        shadow_brightness     = 8'h00;
        shadow_cursor_allowed = 1'b1;
    endfunction

    function automatic void predict_writes(input logic [3:0] code, input logic [6:0] hrs,
                                           input logic [6:0] mins);
        logic [3:0] limit_val;
        logic [1:0] pos;
        event_writes.delete();
        pos = model_cursor[1:0];
        case (code) inside
            REQ_SET_TIME:
            begin
                model_digits[0] = 4'(hrs / 7'd10);
                model_digits[1] = 4'(hrs % 7'd10);
                model_digits[2] = 4'(mins / 7'd10);
                model_digits[3] = 4'(mins % 7'd10);
                for (int d = 0; d < NUM_DIGITS; d++)
                begin
                    if (model_digits[d] <= 4'd9)
                    begin
                        add_write(1'b0, 2'(d), SEG_CODES[model_digits[d]]);
                    end
                end
            end
            REQ_CURSOR_ON:
            begin
                if (shadow_cursor_allowed)
                begin
                    model_cursor = 3'd0;
                end
                else
                begin
                    restore_digit();
                    model_cursor = CURSOR_OFF;
                end
            end
            REQ_CURSOR_OFF:
            begin
                restore_digit();
                model_cursor = CURSOR_OFF;
            end
            REQ_MOVE_LEFT, REQ_MOVE_RIGHT:
            begin
                if (shadow_cursor_allowed && model_cursor < CURSOR_OFF)
                begin
                    restore_digit();
                    if (code == REQ_MOVE_LEFT)
                    begin
                        model_cursor = {1'b0, 2'(pos - 2'd1)};
                    end
                    else
                    begin
                        model_cursor = {1'b0, 2'(pos + 2'd1)};
                    end
                end
            end
            REQ_INCREMENT:
            begin
                if (model_cursor < CURSOR_OFF)
                begin
                    case (pos)
                        2'd0: limit_val = 4'd2;
                        2'd1: limit_val = (model_digits[0] == 4'd2) ? 4'd3 : 4'd9;
                        2'd2: limit_val = 4'd5;
                        default: limit_val = 4'd9;
                    endcase
                    model_digits[pos] = (model_digits[pos] >= limit_val) ? 4'd0
                                                                        : model_digits[pos] + 4'd1;
                end
            end
            REQ_BLINK_TICK:
            begin
                if (model_cursor < CURSOR_OFF)
                begin
                    if (model_blink)
                    begin
                        model_blink = 1'b0;
                        add_write(1'b0, pos, SEG_BLANK);
                    end
                    else
                    begin
                        model_blink = 1'b1;
                        restore_digit();
                    end
                end
            end
            REQ_DISPLAY_OFF:
            begin
                for (int d = 0; d < NUM_DIGITS; d++)
                begin
                    add_write(1'b0, 2'(d), SEG_BLANK);
                end
            end
            REQ_DISPLAY_ON:
            begin
                add_write(1'b1, 2'd0, shadow_brightness);
                for (int d = 0; d < NUM_DIGITS; d++)
                begin
                    add_write(1'b0, 2'(d), SEG_CODES[0]);
                end
            end
            default:
            begin
            end
        endcase
        if (event_writes.size() > 0)
        begin
            event_writes[event_writes.size() - 1].last = 1'b1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // request transfers feed the predictor, write transfers are checked in order
    always @(posedge clk)
    begin : monitor
        write_t seen;
        write_t want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                predict_writes(req_ch.req_type, req_ch.hours, req_ch.minutes);
                if (row_typed == PREDICTED)
                begin
                    foreach (event_writes[k])
                    begin
                        pending_writes.push_back(event_writes[k]);
                    end
                end
                else
                begin
                    for (int k = 0; k < row_typed; k++)
                    begin
                        pending_writes.push_back(typed_writes[typed_ptr]);
                        typed_ptr++;
                    end
                end
            end
            if (disp_ch.valid && disp_ch.ready)
            begin
                seen = '{disp_ch.is_brightness, disp_ch.digit_index, disp_ch.segments,
                         disp_ch.last};
                if (pending_writes.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected write b=%0d idx=%0d seg=%02h last=%0d",
                                              seen.is_brightness, seen.digit_index,
                                              seen.segments, seen.last));
                end
                else
                begin
                    want = pending_writes.pop_front();
                    if (seen !== want)
                    begin
                        report_mismatch($sformatf(
                            "got b=%0d idx=%0d seg=%02h last=%0d, want b=%0d idx=%0d seg=%02h last=%0d",
                            seen.is_brightness, seen.digit_index, seen.segments, seen.last,
                            want.is_brightness, want.digit_index, want.segments, want.last));
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (disp_ch.valid && disp_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin
        disp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            disp_ch.ready = ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_item(input logic [3:0] code, input logic [6:0] hrs,
                             input logic [6:0] mins, input int n_typed);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.req_type = code;
        req_ch.hours    = hrs;
        req_ch.minutes  = mins;
        row_typed       = n_typed;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_random_item();
        int         pick;
        logic [3:0] code;
        logic [6:0] hrs;
        logic [6:0] mins;
        pick = $urandom_range(99);
        if (pick < 8)
            code = REQ_SET_TIME;
        else if (pick < 18)
            code = REQ_CURSOR_ON;
        else if (pick < 24)
            code = REQ_CURSOR_OFF;
        else if (pick < 36)
            code = REQ_MOVE_LEFT;
        else if (pick < 48)
            code = REQ_MOVE_RIGHT;
        else if (pick < 68)
            code = REQ_INCREMENT;
        else if (pick < 84)
            code = REQ_BLINK_TICK;
        else if (pick < 89)
            code = REQ_DISPLAY_OFF;
        else if (pick < 94)
            code = REQ_DISPLAY_ON;
        else
            code = 4'($urandom_range(REQ_UNKNOWN_HI, REQ_UNKNOWN_LO));
        hrs  = ($urandom_range(3) != 0) ? 7'($urandom_range(23)) : 7'($urandom_range(127));
        mins = ($urandom_range(3) != 0) ? 7'($urandom_range(59)) : 7'($urandom_range(127));
        send_item(code, hrs, mins, PREDICTED);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = data;
        if (idx == REG_BRIGHTNESS)
        begin
            shadow_brightness = data;
        end
        else
        begin
            shadow_cursor_allowed = data[0];
        end
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_writes.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    initial
    begin
        logic [7:0] phase_brightness [NUM_PHASES];
        logic       phase_allowed [NUM_PHASES];
        rst_n             = 1'b0;
        wr_en             = 1'b0;
        wr_index          = REG_BRIGHTNESS;
        wr_data           = 8'h00;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_SET_TIME;
        req_ch.hours      = 7'd0;
        req_ch.minutes    = 7'd0;
        row_typed         = PREDICTED;
        typed_ptr         = 0;
        mismatch_count    = 0;
        sender_idle_pct   = 38;
        receiver_idle_pct = 86;
        reset_model();

        phase_brightness = '{8'hff, 8'h00, 8'($urandom), 8'($urandom), 8'h80, 8'($urandom)};
        phase_allowed    = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1};

        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            send_item(directed_rows[r].code, directed_rows[r].hrs, directed_rows[r].mins,
                      directed_rows[r].n_typed);
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            req_ch.valid = 1'b0;
            wait_drained();
            repeat (DRAIN_CYCLES) @(negedge clk);
            write_reg(REG_BRIGHTNESS, phase_brightness[p]);
            write_reg(REG_CURSOR_ALLOWED, {7'd0, phase_allowed[p]});
            wr_en = 1'b0;
            case (p / 2)
                0:
                begin
                    sender_idle_pct   = 38;
                    receiver_idle_pct = 86;
                end
                1:
                begin
                    sender_idle_pct   = 86;
                    receiver_idle_pct = 38;
                end
                default:
                begin
                    sender_idle_pct   = 0;
                    receiver_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        req_ch.valid = 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (pending_writes.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected writes never arrived",
                                      pending_writes.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
